FILE: hw/rtl/ilb_pkg.sv
package ilb_pkg;

  localparam int ActionW = 2;
  localparam int ModeW   = 2;
  localparam int IndexW  = 7;
  localparam int DataW   = 32;
  localparam int StatusW = 2;
  localparam int CountW  = 7;

  localparam logic [ActionW-1:0] ACT_INSERT = 2'd0;
  localparam logic [ActionW-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ActionW-1:0] ACT_READ   = 2'd2;

  localparam logic [ModeW-1:0] MODE_INDEX = 2'd0;
  localparam logic [ModeW-1:0] MODE_FRONT = 2'd1;
  localparam logic [ModeW-1:0] MODE_BACK  = 2'd2;

  localparam logic [StatusW-1:0] ST_OK      = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY   = 2'd1;
  localparam logic [StatusW-1:0] ST_INVALID = 2'd2;
  localparam logic [StatusW-1:0] ST_FULL    = 2'd3;

  // Shift control broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic rem;
  } ilb_ctl_t;

endpackage

FILE: hw/rtl/ilb_cell.sv
module ilb_cell import ilb_pkg::*; #(
  parameter int PosW = 6,
  parameter int Idx  = 0
) (
  input  logic                    clk,
  input  ilb_ctl_t                ctl,
  input  logic [PosW-1:0]         pos,
  input  logic signed [DataW-1:0] value,
  input  logic signed [DataW-1:0] prev_entry,
  input  logic signed [DataW-1:0] next_entry,
  output logic signed [DataW-1:0] entry,
  output logic signed [DataW-1:0] tap
);

  localparam logic [PosW-1:0] MyPos = PosW'(Idx);

  logic hit;
  logic above;

  assign hit   = (pos == MyPos);
  assign above = (MyPos > pos);

  // Insert: take the neighbor in front, or the new value at the slot itself.
  // Remove: take the neighbor behind from the slot onward.
  always_ff @(posedge clk) begin
    if (ctl.ins && above) begin
      entry <= prev_entry;
    end else if (ctl.ins && hit) begin
      entry <= value;
    end else if (ctl.rem && (above || hit)) begin
      entry <= next_entry;
    end
  end

  assign tap = hit ? entry : '0;

endmodule

FILE: hw/rtl/indexed_list_buffer.sv
// Result strobe (done) rises in the cycle after the command is taken.
// Throughput: one command per clock; busy is never raised, since the cell
// chain shifts entries from the slot on in the same cycle as the command.
// Reset: rst (synchronous) empties the list and drops done; stored entries
// keep their contents and are never read before being written.
module indexed_list_buffer import ilb_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [ActionW-1:0]        action,
  input  logic [ModeW-1:0]          position_mode,
  input  logic [IndexW-1:0]         index,
  input  logic signed [DataW-1:0]   value,
  output logic                      done,
  output logic [StatusW-1:0]        status,
  output logic signed [DataW-1:0]   read_value,
  output logic [CountW-1:0]         count
);

  localparam int PosW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int W    = (CntW > IndexW) ? CntW : IndexW;

  logic [CntW-1:0]   cnt;
  logic [CntW-1:0]   cnt_next;
  logic [W-1:0]      cnt_w;
  logic [W-1:0]      pos_w;
  logic [StatusW-1:0] status_c;
  logic              accept;
  logic              do_ins;
  logic              do_rem;
  logic              do_read;
  ilb_ctl_t          ctl;

  logic signed [DataW-1:0] entries [CAPACITY];
  logic signed [DataW-1:0] taps    [CAPACITY];
  logic signed [DataW-1:0] rd_data;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cnt_w  = W'(cnt);

  always_comb begin
    unique case (position_mode)
      MODE_INDEX: pos_w = W'(index);
      MODE_FRONT: pos_w = '0;
      MODE_BACK:  pos_w = (action == ACT_INSERT) ? cnt_w : cnt_w - W'(1);
      default:    pos_w = '0;
    endcase
  end

  always_comb begin
    status_c = ST_OK;
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    do_read  = 1'b0;
    if (action != ACT_INSERT && action != ACT_REMOVE && action != ACT_READ) begin
      status_c = ST_INVALID;
    end else if (position_mode != MODE_INDEX && position_mode != MODE_FRONT &&
                 position_mode != MODE_BACK) begin
      status_c = ST_INVALID;
    end else if (action == ACT_INSERT) begin
      if (cnt_w >= W'(CAPACITY)) begin
        status_c = ST_FULL;
      end else if (pos_w > cnt_w) begin
        status_c = ST_INVALID;
      end else begin
        do_ins = 1'b1;
      end
    end else if (cnt == '0) begin
      status_c = ST_EMPTY;
    end else if (pos_w >= cnt_w) begin
      status_c = ST_INVALID;
    end else if (action == ACT_REMOVE) begin
      do_rem = 1'b1;
    end else begin
      do_read = 1'b1;
    end
  end

  assign ctl.ins = accept && do_ins;
  assign ctl.rem = accept && do_rem;

  always_comb begin
    cnt_next = cnt;
    if (ctl.ins) begin
      cnt_next = cnt + CntW'(1);
    end else if (ctl.rem) begin
      cnt_next = cnt - CntW'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ilb_cell #(
      .PosW (PosW),
      .Idx  (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (pos_w[PosW-1:0]),
      .value      (value),
      .prev_entry ((i == 0) ? value : entries[(i == 0) ? 0 : i - 1]),
      .next_entry ((i == CAPACITY - 1) ? entries[i] :
                   entries[(i == CAPACITY - 1) ? i : i + 1]),
      .entry      (entries[i]),
      .tap        (taps[i])
    );
  end

  // Only the addressed cell drives a nonzero tap
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | taps[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      cnt  <= cnt_next;
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= status_c;
      read_value <= do_read ? rd_data : '0;
      count      <= CountW'(W'(cnt_next));
    end
  end

endmodule

FILE: tb/indexed_list_buffer_test.sv
`timescale 1ns / 1ps

module indexed_list_buffer_test;
  import ilb_pkg::*;

  localparam int Depth     = 64;
  localparam int IdleLimit = 1000;

  // Codes outside the defined set, used to hit the rejection paths
  localparam logic [ActionW-1:0] ACT_UNKNOWN  = 2'd3;
  localparam logic [ModeW-1:0]   MODE_UNKNOWN = 2'd3;

  localparam logic signed [DataW-1:0] VAL_MIN  = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] VAL_MAX  = 32'sh7fff_ffff;
  localparam logic signed [DataW-1:0] VAL_ZERO = 32'sh0000_0000;
  localparam logic signed [DataW-1:0] VAL_ONES = 32'shffff_ffff;

  typedef struct {
    logic [StatusW-1:0]      status;
    logic signed [DataW-1:0] read_value;
    logic [CountW-1:0]       count;
  } list_result_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic [ActionW-1:0]        action = '0;
  logic [ModeW-1:0]          position_mode = '0;
  logic [IndexW-1:0]         index = '0;
  logic signed [DataW-1:0]   value = '0;
  logic                      done;
  logic [StatusW-1:0]        status;
  logic signed [DataW-1:0]   read_value;
  logic [CountW-1:0]         count;

  logic signed [DataW-1:0] list_contents[$];
  list_result_t            pending_results[$];
  list_result_t            head_result;
  int                      error_count = 0;
  int                      idle_cycles = 0;
  int                      gap_limit = 16;

  indexed_list_buffer #(
    .CAPACITY(Depth)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .position_mode(position_mode),
    .index        (index),
    .value        (value),
    .done         (done),
    .status       (status),
    .read_value   (read_value),
    .count        (count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Apply one command to the list copy and return the result it must produce
  function automatic list_result_t apply_list_command(logic [ActionW-1:0] act,
                                                      logic [ModeW-1:0] mode,
                                                      logic [IndexW-1:0] idx,
                                                      logic signed [DataW-1:0] val);
    list_result_t r;
    int n;
    int pos;
    n = list_contents.size();
    r.status = ST_OK;
    r.read_value = '0;
    if (act == ACT_UNKNOWN || mode == MODE_UNKNOWN) begin
      r.status = ST_INVALID;
    end else if (act == ACT_INSERT) begin
      if (n >= Depth) begin
        r.status = ST_FULL;
      end else begin
        if (mode == MODE_INDEX) pos = int'(idx);
        else if (mode == MODE_FRONT) pos = 0;
        else pos = n;
        if (pos > n) r.status = ST_INVALID;
        else list_contents.insert(pos, val);
      end
    end else if (n == 0) begin
      r.status = ST_EMPTY;
    end else begin
      if (mode == MODE_INDEX) pos = int'(idx);
      else if (mode == MODE_FRONT) pos = 0;
      else pos = n - 1;
      if (pos >= n) r.status = ST_INVALID;
      else if (act == ACT_READ) r.read_value = list_contents[pos];
      else list_contents.delete(pos);
    end
    r.count = CountW'(list_contents.size());
    return r;
  endfunction

  // Issue one transaction after a random gap; record its expected result once taken
  task automatic send_cmd(logic [ActionW-1:0] act, logic [ModeW-1:0] mode,
                          logic [IndexW-1:0] idx, logic signed [DataW-1:0] val);
    int gap;
    gap = $urandom_range(0, gap_limit);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    action        <= act;
    position_mode <= mode;
    index         <= idx;
    value         <= val;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_list_command(act, mode, idx, val));
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  task automatic test_empty_list();
    send_cmd(ACT_REMOVE, MODE_INDEX, 7'd0, VAL_ZERO);
    send_cmd(ACT_READ, MODE_FRONT, 7'd0, VAL_ZERO);
    send_cmd(ACT_REMOVE, MODE_BACK, 7'd0, VAL_ZERO);
    send_cmd(ACT_READ, MODE_INDEX, 7'd127, VAL_ZERO);
    send_cmd(ACT_INSERT, MODE_INDEX, 7'd1, VAL_ONES);
  endtask

  task automatic test_unknown_codes();
    send_cmd(ACT_UNKNOWN, MODE_INDEX, 7'd0, VAL_MAX);
    // mode check wins over the empty-list check
    send_cmd(ACT_READ, MODE_UNKNOWN, 7'd0, VAL_ZERO);
    send_cmd(ACT_INSERT, MODE_UNKNOWN, 7'd0, VAL_MAX);
    send_cmd(ACT_UNKNOWN, MODE_UNKNOWN, 7'd127, VAL_ONES);
  endtask

  task automatic test_positions();
    send_cmd(ACT_INSERT, MODE_FRONT, 7'd0, VAL_MIN);
    send_cmd(ACT_INSERT, MODE_BACK, 7'd0, VAL_MAX);
    send_cmd(ACT_INSERT, MODE_INDEX, 7'd1, VAL_ZERO);
    send_cmd(ACT_INSERT, MODE_INDEX, 7'd3, VAL_ONES);
    send_cmd(ACT_INSERT, MODE_INDEX, 7'd5, VAL_ZERO);
    send_cmd(ACT_READ, MODE_FRONT, 7'd0, VAL_ZERO);
    send_cmd(ACT_READ, MODE_INDEX, 7'd1, VAL_ZERO);
    send_cmd(ACT_READ, MODE_INDEX, 7'd2, VAL_ZERO);
    send_cmd(ACT_READ, MODE_BACK, 7'd0, VAL_ZERO);
    send_cmd(ACT_READ, MODE_INDEX, 7'd4, VAL_ZERO);
    send_cmd(ACT_REMOVE, MODE_INDEX, 7'd127, VAL_ZERO);
    send_cmd(ACT_REMOVE, MODE_INDEX, 7'd1, VAL_ZERO);
    send_cmd(ACT_REMOVE, MODE_FRONT, 7'd0, VAL_ZERO);
    send_cmd(ACT_REMOVE, MODE_BACK, 7'd0, VAL_ZERO);
    send_cmd(ACT_READ, MODE_FRONT, 7'd0, VAL_ZERO);
    send_cmd(ACT_REMOVE, MODE_INDEX, 7'd0, VAL_ZERO);
  endtask

  task automatic test_full_list();
    logic signed [DataW-1:0] v;
    while (list_contents.size() < Depth) begin
      v = $urandom;
      send_cmd(ACT_INSERT, MODE_BACK, 7'd0, v);
    end
    // full check comes before the index check
    send_cmd(ACT_INSERT, MODE_INDEX, 7'd127, VAL_ONES);
    send_cmd(ACT_INSERT, MODE_FRONT, 7'd0, VAL_ONES);
    send_cmd(ACT_READ, MODE_INDEX, 7'd63, VAL_ZERO);
    send_cmd(ACT_READ, MODE_INDEX, 7'd64, VAL_ZERO);
    send_cmd(ACT_REMOVE, MODE_INDEX, 7'd63, VAL_ZERO);
    send_cmd(ACT_INSERT, MODE_INDEX, 7'd63, VAL_MIN);
    send_cmd(ACT_READ, MODE_BACK, 7'd0, VAL_ZERO);
    wait_for_results();
  endtask

  task automatic random_commands(int num, int insert_pct);
    logic [ActionW-1:0]      act;
    logic [ModeW-1:0]        mode;
    logic [IndexW-1:0]       idx;
    logic signed [DataW-1:0] v;
    int                      sel;
    repeat (num) begin
      if ($urandom_range(0, 99) < 4) act = ACT_UNKNOWN;
      else if ($urandom_range(0, 99) < insert_pct) act = ACT_INSERT;
      else if ($urandom_range(0, 1) == 0) act = ACT_REMOVE;
      else act = ACT_READ;

      sel = $urandom_range(0, 99);
      if (sel < 4) mode = MODE_UNKNOWN;
      else if (sel < 55) mode = MODE_INDEX;
      else if (sel < 78) mode = MODE_FRONT;
      else mode = MODE_BACK;

      // mostly legal positions, sometimes anywhere in the field
      if ($urandom_range(0, 99) < 85) idx = IndexW'($urandom_range(0, list_contents.size()));
      else idx = IndexW'($urandom_range(0, 127));

      case ($urandom_range(0, 19))
        0: v = VAL_MIN;
        1: v = VAL_MAX;
        2: v = VAL_ZERO;
        3: v = VAL_ONES;
        default: v = $urandom;
      endcase
      send_cmd(act, mode, idx, v);
    end
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 10; phase++) begin
      case (phase % 3)
        0: gap_limit = 16;
        1: gap_limit = 0;
        default: gap_limit = 4;
      endcase
      random_commands(100, (phase % 2 == 0) ? 75 : 30);
      if (phase % 4 == 3) wait_for_results();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_unknown_codes();
    test_positions();
    wait_for_results();
    test_full_list();
    test_random_traffic();
    wait_for_results();
    repeat (4) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("indexed_list_buffer test passed");
    end else begin
      $display("indexed_list_buffer test failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result strobe with no transaction outstanding");
        error_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (status !== head_result.status) begin
          $error("status mismatch: expected %0d, got %0d", head_result.status, status);
          error_count++;
        end
        if (read_value !== head_result.read_value) begin
          $error("read_value mismatch: expected %0d, got %0d",
                 head_result.read_value, read_value);
          error_count++;
        end
        if (count !== head_result.count) begin
          $error("count mismatch: expected %0d, got %0d", head_result.count, count);
          error_count++;
        end
      end
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("indexed_list_buffer test failed");
      $finish;
    end
  end

endmodule

FILE: filelist.f
hw/rtl/ilb_pkg.sv
hw/rtl/ilb_cell.sv
hw/rtl/indexed_list_buffer.sv
tb/indexed_list_buffer_test.sv
